[rtl/mcq_pkg.sv]
// Shared types and constants for the multiple circular queue block.
// No dependencies; used by mcq_ctrl, mcq_store and multi_circular_queue.
package mcq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int NUM_QUEUES  = 4;
  localparam int DATA_WIDTH  = 32;

  localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int QID_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;
  localparam logic [1:0] OP_SIZE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [1:0]         queue_id;
    logic signed [31:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         status;
    logic [3:0]         occupancy;
  } rsp_t;

  // access to the element store
  typedef struct packed {
    logic                  wr;
    logic                  rd;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_WIDTH-1:0] wdata;
  } mem_op_t;

  // result fields known at request time, registered alongside the read
  typedef struct packed {
    logic       valid;
    logic       has_data;
    logic [1:0] status;
    logic [3:0] occupancy;
  } res_info_t;

endpackage

[rtl/multi_circular_queue.sv]
// Top level: bank of circular FIFO queues over one shared element store.
// Depends on mcq_pkg, mcq_ctrl and mcq_store.
//
//  channel   handshake          payload   direction
//  command   start / busy       cmd       in
//  result    done (strobe)      result    out
//
// Rate: one word accepted per cycle; its result shows in the next cycle,
//   with the registered read of the element store RAM.
// busy stays low: each request touches the store at most once (write or read),
//   and a written word is readable by any later request, so no hazard exists.
// Reset: synchronous; clears all heads, tails and counts. Store contents are
//   left as they are; only entries that were enqueued are ever read.
// Stalls: none; the receiver takes each result in its single done cycle.
module multi_circular_queue
  import mcq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t cmd,
  output logic done,
  output rsp_t result
);

  logic                  accept;
  mem_op_t               mem_op;
  res_info_t             info;
  logic [DATA_WIDTH-1:0] rdata;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // pointers, counts and decisions
  mcq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .mem_op (mem_op),
    .info   (info)
  );

  // shared element RAM
  mcq_store u_store (
    .clk   (clk),
    .op    (mem_op),
    .rdata (rdata)
  );

  // read data lands with the registered result fields; zero when no read
  assign done             = info.valid;
  assign result.data_out  = info.has_data ? 32'(rdata) : '0;
  assign result.status    = info.status;
  assign result.occupancy = info.occupancy;

`ifndef SYNTHESIS
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> done) else $error("no result after accepted word");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done) else $error("result without accepted word");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> result.occupancy == 4'(QUEUE_DEPTH))
    else $error("full status with wrong occupancy");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_EMPTY) |-> (result.occupancy == '0 &&
    result.data_out == '0)) else $error("empty status with data or count");
`endif

endmodule

[rtl/mcq_store.sv]
// Element store: one synchronous RAM, one access per cycle, registered read.
// Depends on mcq_pkg.
module mcq_store
  import mcq_pkg::*;
(
  input  logic                  clk,
  input  mem_op_t               op,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (op.wr) begin
      mem[op.addr] <= op.wdata;
    end
    if (op.rd) begin
      rdata <= mem[op.addr];
    end
  end

endmodule

[rtl/mcq_ctrl.sv]
// Per-queue head, tail and count registers; full/empty decisions and
// store address generation. Depends on mcq_pkg.
module mcq_ctrl
  import mcq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  req_t      cmd,
  output mem_op_t   mem_op,
  output res_info_t info
);

  logic [SLOT_W-1:0] head  [NUM_QUEUES];
  logic [SLOT_W-1:0] tail  [NUM_QUEUES];
  logic [CNT_W-1:0]  count [NUM_QUEUES];

  logic [QID_W-1:0]  qidx;
  logic              qvalid;
  logic [SLOT_W-1:0] cur_head;
  logic [SLOT_W-1:0] cur_tail;
  logic [CNT_W-1:0]  cur_count;
  logic              is_full;
  logic              is_empty;
  logic              do_enq;
  logic              do_deq;
  logic              do_peek;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  count_next;
  res_info_t         info_next;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  assign qidx      = QID_W'(cmd.queue_id);
  assign qvalid    = int'(cmd.queue_id) < NUM_QUEUES;
  assign cur_head  = head[qidx];
  assign cur_tail  = tail[qidx];
  assign cur_count = count[qidx];
  assign is_full   = cur_count == CNT_W'(QUEUE_DEPTH);
  assign is_empty  = cur_count == '0;

  always_comb begin
    do_enq     = 1'b0;
    do_deq     = 1'b0;
    do_peek    = 1'b0;
    count_next = cur_count;
    info_next  = '0;
    info_next.valid = accept;
    if (!qvalid) begin
      info_next.status = ST_EMPTY;
    end else begin
      case (cmd.opcode)
        OP_ENQ: begin
          if (is_full) begin
            info_next.status = ST_FULL;
          end else begin
            do_enq     = accept;
            count_next = cur_count + 1'b1;
          end
        end
        OP_DEQ: begin
          if (is_empty) begin
            info_next.status = ST_EMPTY;
          end else begin
            do_deq     = accept;
            count_next = cur_count - 1'b1;
          end
        end
        OP_PEEK: begin
          if (is_empty) begin
            info_next.status = ST_EMPTY;
          end else begin
            do_peek = accept;
          end
        end
        default: begin
        end
      endcase
      info_next.occupancy = 4'(count_next);
    end
    info_next.has_data = do_deq | do_peek;
  end

  assign slot          = do_enq ? cur_tail : cur_head;
  assign mem_op.wr     = do_enq;
  assign mem_op.rd     = do_deq | do_peek;
  assign mem_op.addr   = ADDR_W'(qidx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
  assign mem_op.wdata  = DATA_WIDTH'(cmd.data_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
      info <= '0;
    end else begin
      info <= info_next;
      if (do_enq) begin
        tail[qidx]  <= next_slot(cur_tail);
        count[qidx] <= count_next;
      end
      if (do_deq) begin
        head[qidx]  <= next_slot(cur_head);
        count[qidx] <= count_next;
      end
    end
  end

endmodule

[dv/tb_multi_circular_queue.sv]
// Self-checking testbench for multi_circular_queue: directed and random queue requests.
// Depends on mcq_pkg and the multi_circular_queue RTL; holds its own queue-bank predictor.
`timescale 1ns / 1ps

module tb_multi_circular_queue;
  import mcq_pkg::*;

  // Predictor of the queue bank plus the list of responses still owed by the DUT.
  class queue_bank_model;
    logic [DATA_WIDTH-1:0] slot_data [ENTRIES];
    logic [SLOT_W-1:0]     head_slot [NUM_QUEUES];
    logic [SLOT_W-1:0]     tail_slot [NUM_QUEUES];
    int unsigned           fill_count [NUM_QUEUES];
    rsp_t                  expected_rsp [$];
    int                    errors;
    int                    checked;
    int                    full_hits;
    int                    empty_hits;

    function new();
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_slot[q]  = '0;
        tail_slot[q]  = '0;
        fill_count[q] = 0;
      end
      errors     = 0;
      checked    = 0;
      full_hits  = 0;
      empty_hits = 0;
    endfunction

    function logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] s);
      return (int'(s) == QUEUE_DEPTH - 1) ? '0 : s + 1'b1;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    // Apply one accepted request to the model and queue the response it owes.
    function void note_request(req_t w);
      rsp_t r;
      int   q;
      int   base;
      r = '0;
      r.status = ST_OK;
      if (int'(w.queue_id) >= NUM_QUEUES) begin
        r.status = ST_EMPTY;
      end else begin
        q    = int'(w.queue_id);
        base = q * QUEUE_DEPTH;
        case (w.opcode)
          OP_ENQ: begin
            if (fill_count[q] >= QUEUE_DEPTH) begin
              r.status = ST_FULL;
            end else begin
              slot_data[base + int'(tail_slot[q])] = w.data_in[DATA_WIDTH-1:0];
              tail_slot[q] = next_slot(tail_slot[q]);
              fill_count[q]++;
            end
          end
          OP_DEQ: begin
            if (fill_count[q] == 0) begin
              r.status = ST_EMPTY;
            end else begin
              r.data_out = slot_data[base + int'(head_slot[q])];
              head_slot[q] = next_slot(head_slot[q]);
              fill_count[q]--;
            end
          end
          OP_PEEK: begin
            if (fill_count[q] == 0) r.status = ST_EMPTY;
            else r.data_out = slot_data[base + int'(head_slot[q])];
          end
          default: ;
        endcase
        r.occupancy = 4'(fill_count[q]);
      end
      expected_rsp.push_back(r);
    endfunction

    // Compare one response from the DUT with the oldest one owed.
    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected response data_out=%h status=%0d occupancy=%0d",
                 $time, got.data_out, got.status, got.occupancy);
        errors++;
        return;
      end
      want = expected_rsp.pop_front();
      checked++;
      if (want.status == ST_FULL)  full_hits++;
      if (want.status == ST_EMPTY) empty_hits++;
      if (got.data_out !== want.data_out) begin
        $display("%0t: data_out mismatch expected %h actual %h",
                 $time, want.data_out, got.data_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch expected %0d actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $display("%0t: occupancy mismatch expected %0d actual %0d",
                 $time, want.occupancy, got.occupancy);
        errors++;
      end
    endfunction
  endclass

  localparam int RANDOM_WORDS = 1600;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic done;
  req_t cmd;
  rsp_t result;

  queue_bank_model bank_model = new();
  int              words_sent = 0;

  multi_circular_queue DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample at the rising edge: inputs and DUT outputs both change through
  // nonblocking updates, so here we see the values of the cycle just ended.
  // The request is noted before the response is checked, so the order is
  // right for any latency.
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (start === 1'b1 && busy === 1'b0) bank_model.note_request(cmd);
      if (done === 1'b1) bank_model.check_response(result);
    end
  end

  // Present one word and hold it until the block takes it. Returns in the
  // step of acceptance, so the next word can follow back to back.
  task automatic send_word(input logic [1:0] op, input logic [1:0] qid,
                           input logic [31:0] value);
    req_t w;
    w.opcode   = op;
    w.queue_id = qid;
    w.data_in  = value;
    cmd   <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    words_sent++;
  endtask

  // Sender gap; cmd carries junk while start is low, which must be ignored.
  task automatic idle_for(input int cycles);
    req_t junk;
    if (cycles > 0) begin
      junk  = req_t'({$urandom, $urandom});
      start <= 1'b0;
      cmd   <= junk;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold off until every owed response has come back.
  task automatic drain_pending();
    start <= 1'b0;
    @(posedge clk);
    while (bank_model.pending() != 0) @(posedge clk);
  endtask

  // Opcode mix per burst style: 0 leans to filling, 1 to draining, 2 even.
  function automatic logic [1:0] pick_op(input int mode);
    int roll;
    int enq_pct;
    int deq_pct;
    roll    = $urandom_range(0, 99);
    enq_pct = (mode == 0) ? 55 : (mode == 1) ? 20 : 40;
    deq_pct = (mode == 0) ? 20 : (mode == 1) ? 55 : 35;
    if (roll < enq_pct)                 return OP_ENQ;
    if (roll < enq_pct + deq_pct)       return OP_DEQ;
    if (roll < enq_pct + deq_pct + 15)  return OP_PEEK;
    return OP_SIZE;
  endfunction

  // Mostly random data, with the corner values mixed in now and then.
  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int burst_len;
    int mode;
    int focus_q;
    bit use_focus;
    bit paused;
    int sent_random;
    logic [1:0] qid;

    rst   <= 1'b1;
    start <= 1'b0;
    cmd   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-queue dequeue and peek, size of an empty queue.
    send_word(OP_DEQ,  2'd0, 32'h1234_5678);
    send_word(OP_PEEK, 2'd0, 32'h0);
    send_word(OP_SIZE, 2'd0, 32'hFFFF_FFFF);
    // Fill queue 0 to the brim with corner values, then one enqueue too many.
    send_word(OP_ENQ,  2'd0, 32'h8000_0000);
    send_word(OP_ENQ,  2'd0, 32'h7FFF_FFFF);
    send_word(OP_ENQ,  2'd0, 32'h0000_0000);
    send_word(OP_ENQ,  2'd0, 32'hFFFF_FFFF);
    send_word(OP_ENQ,  2'd0, 32'hAAAA_AAAA);
    send_word(OP_ENQ,  2'd0, 32'h5555_5555);
    send_word(OP_ENQ,  2'd0, 32'h0000_0001);
    send_word(OP_ENQ,  2'd0, 32'hFFFF_FFFE);
    send_word(OP_ENQ,  2'd0, 32'hDEAD_BEEF);
    send_word(OP_PEEK, 2'd0, 32'h0);
    send_word(OP_SIZE, 2'd0, 32'h0);
    send_word(OP_DEQ,  2'd0, 32'h0);
    send_word(OP_DEQ,  2'd0, 32'h0);
    // Top queue id: one value in and out, then empty again.
    send_word(OP_ENQ,  2'd3, 32'hC0DE_0003);
    send_word(OP_SIZE, 2'd3, 32'h0);
    send_word(OP_PEEK, 2'd3, 32'h0);
    send_word(OP_DEQ,  2'd3, 32'h0);
    send_word(OP_DEQ,  2'd3, 32'h0);
    send_word(OP_ENQ,  2'd1, 32'h0F0F_0F0F);
    send_word(OP_ENQ,  2'd2, 32'hF0F0_F0F0);
    drain_pending();

    // Random: bursts of one style, sometimes aimed at one queue so it hits
    // full or empty and wraps; random gaps, some zero for back-to-back runs.
    sent_random = 0;
    paused      = 1'b0;
    while (sent_random < RANDOM_WORDS) begin
      burst_len = $urandom_range(1, 48);
      mode      = $urandom_range(0, 2);
      use_focus = ($urandom_range(0, 2) != 0);
      focus_q   = $urandom_range(0, NUM_QUEUES - 1);
      repeat (burst_len) begin
        qid = use_focus ? 2'(focus_q) : 2'($urandom_range(0, 3));
        send_word(pick_op(mode), qid, pick_data());
        sent_random++;
      end
      // once mid-run: stop and let everything come back before going on
      if (!paused && sent_random >= RANDOM_WORDS / 2) begin
        paused = 1'b1;
        drain_pending();
      end else if ($urandom_range(0, 3) != 0) begin
        idle_for($urandom_range(1, 6));
      end
    end

    drain_pending();
    // wait on further edges to catch any stray strobe
    repeat (4) @(posedge clk);

    $display("Sent %0d words over %0d queues; %0d responses checked.",
             words_sent, NUM_QUEUES, bank_model.checked);
    $display("Responses with full status: %0d, with empty status: %0d.",
             bank_model.full_hits, bank_model.empty_hits);
    if (bank_model.errors == 0 && bank_model.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the time a correct run needs.
  initial begin
    #2_000_000;
    $display("Timeout with %0d responses outstanding", bank_model.pending());
    $display("TEST FAILED");
    $finish;
  end

endmodule
